### hw/rtl/cmt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the microcode ROM for the counted-set mex tracker.
// No dependencies; every other file but cmt_ram imports this package.
package cmt_pkg;

    // Store geometry. Blocks are a power of two so a value's block is a shift.
    localparam int VALUE_RANGE = 1024;
    localparam int BLOCK_LOG2  = 5;
    localparam int BLOCK_SIZE  = 1 << BLOCK_LOG2;
    localparam int NUM_BLOCKS  = (VALUE_RANGE + BLOCK_SIZE - 1) / BLOCK_SIZE;

    // Field widths of the item channels and the limit register.
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 10;
    localparam int LIM_W    = 11;
    localparam int STATUS_W = 2;

    localparam int ADDR_W  = $clog2(VALUE_RANGE);
    localparam int COUNT_W = 16;
    localparam int BIDX_W  = $clog2(NUM_BLOCKS);
    localparam int BLK_W   = $clog2(NUM_BLOCKS + 1);
    localparam int BCNT_W  = $clog2(BLOCK_SIZE + 1);
    localparam int START_W = BLK_W + BLOCK_LOG2;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [LIM_W-1:0]   LIMIT_RESET = LIM_W'(1024);

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

    // Datapath micro-operations
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] A_NOP       = 4'd0;
    localparam logic [ACT_W-1:0] A_FETCH     = 4'd1;
    localparam logic [ACT_W-1:0] A_READ_VAL  = 4'd2;
    localparam logic [ACT_W-1:0] A_INC       = 4'd3;
    localparam logic [ACT_W-1:0] A_DEC       = 4'd4;
    localparam logic [ACT_W-1:0] A_BLK_STEP  = 4'd5;
    localparam logic [ACT_W-1:0] A_SCAN_INIT = 4'd6;
    localparam logic [ACT_W-1:0] A_SCAN      = 4'd7;
    localparam logic [ACT_W-1:0] A_MEX_HIT   = 4'd8;
    localparam logic [ACT_W-1:0] A_MEX_LIM   = 4'd9;
    localparam logic [ACT_W-1:0] A_CLR_INIT  = 4'd10;
    localparam logic [ACT_W-1:0] A_CLR_STEP  = 4'd11;
    localparam logic [ACT_W-1:0] A_BOOT_DONE = 4'd12;
    localparam logic [ACT_W-1:0] A_EMIT      = 4'd13;

    // Branch condition selects
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
    localparam logic [COND_W-1:0] C_OUT_RANGE = 3'd1;
    localparam logic [COND_W-1:0] C_BLK_MORE  = 3'd2;
    localparam logic [COND_W-1:0] C_PAST_LIM  = 3'd3;
    localparam logic [COND_W-1:0] C_SCAN_MISS = 3'd4;
    localparam logic [COND_W-1:0] C_CLR_MORE  = 3'd5;
    localparam logic [COND_W-1:0] C_BOOT      = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_BUSY  = 3'd7;

    // Microcode addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] U_FETCH    = 4'd0;
    localparam logic [UPC_W-1:0] U_INS_RD   = 4'd1;
    localparam logic [UPC_W-1:0] U_INS_UPD  = 4'd2;
    localparam logic [UPC_W-1:0] U_REM_RD   = 4'd3;
    localparam logic [UPC_W-1:0] U_REM_UPD  = 4'd4;
    localparam logic [UPC_W-1:0] U_Q_BLK    = 4'd5;
    localparam logic [UPC_W-1:0] U_Q_SEL    = 4'd6;
    localparam logic [UPC_W-1:0] U_Q_SCAN   = 4'd7;
    localparam logic [UPC_W-1:0] U_Q_HIT    = 4'd8;
    localparam logic [UPC_W-1:0] U_Q_LIM    = 4'd9;
    localparam logic [UPC_W-1:0] U_CLR_INIT = 4'd10;
    localparam logic [UPC_W-1:0] U_CLR      = 4'd11;
    localparam logic [UPC_W-1:0] U_CLR_END  = 4'd12;
    localparam logic [UPC_W-1:0] U_EMIT     = 4'd13;

    typedef struct packed {
        logic              disp;   // dispatch on the incoming op
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  tgt_t;  // taken when cond holds
        logic [UPC_W-1:0]  tgt_f;
        logic [ACT_W-1:0]  act;
    } cmt_uword_t;

    typedef struct packed {
        logic             fire;
        logic [OP_W-1:0]  op;
        logic             out_range;
        logic             blk_more;
        logic             past_lim;
        logic             scan_miss;
        logic             clr_more;
        logic             boot;
        logic             out_busy;
    } cmt_cond_t;

    function automatic cmt_uword_t uw(input logic [COND_W-1:0] c,
                                      input logic [UPC_W-1:0] t,
                                      input logic [UPC_W-1:0] f,
                                      input logic [ACT_W-1:0] a);
        cmt_uword_t w;
        w.disp  = 1'b0;
        w.cond  = c;
        w.tgt_t = t;
        w.tgt_f = f;
        w.act   = a;
        return w;
    endfunction

    // Control store
    function automatic cmt_uword_t cmt_urom(input logic [UPC_W-1:0] addr);
        cmt_uword_t w;
        w = uw(C_ALWAYS, U_FETCH, U_FETCH, A_NOP);
        unique case (addr)
            U_FETCH:
            begin
                w      = uw(C_ALWAYS, U_FETCH, U_FETCH, A_FETCH);
                w.disp = 1'b1;
            end
            U_INS_RD:   w = uw(C_OUT_RANGE, U_EMIT, U_INS_UPD, A_READ_VAL);
            U_INS_UPD:  w = uw(C_ALWAYS, U_EMIT, U_EMIT, A_INC);
            U_REM_RD:   w = uw(C_OUT_RANGE, U_EMIT, U_REM_UPD, A_READ_VAL);
            U_REM_UPD:  w = uw(C_ALWAYS, U_EMIT, U_EMIT, A_DEC);
            U_Q_BLK:    w = uw(C_BLK_MORE, U_Q_BLK, U_Q_SEL, A_BLK_STEP);
            U_Q_SEL:    w = uw(C_PAST_LIM, U_Q_LIM, U_Q_SCAN, A_SCAN_INIT);
            U_Q_SCAN:   w = uw(C_SCAN_MISS, U_Q_SCAN, U_Q_HIT, A_SCAN);
            U_Q_HIT:    w = uw(C_ALWAYS, U_EMIT, U_EMIT, A_MEX_HIT);
            U_Q_LIM:    w = uw(C_ALWAYS, U_EMIT, U_EMIT, A_MEX_LIM);
            U_CLR_INIT: w = uw(C_ALWAYS, U_CLR, U_CLR, A_CLR_INIT);
            U_CLR:      w = uw(C_CLR_MORE, U_CLR, U_CLR_END, A_CLR_STEP);
            U_CLR_END:  w = uw(C_BOOT, U_FETCH, U_EMIT, A_BOOT_DONE);
            U_EMIT:     w = uw(C_OUT_BUSY, U_EMIT, U_FETCH, A_EMIT);
            default:    w = uw(C_ALWAYS, U_FETCH, U_FETCH, A_NOP);
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/cmt_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying op and value.
// Depends on cmt_pkg for field widths.
interface cmt_req_if
    import cmt_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

### hw/rtl/cmt_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying mex_value and status.
// Depends on cmt_pkg for field widths.
interface cmt_rsp_if
    import cmt_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [LIM_W-1:0]    mex_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output mex_value, output status, input ready);
    modport sink   (input valid, input mex_value, input status, output ready);
endinterface

### hw/rtl/cmt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/cmt_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and branch select.
// Depends on cmt_pkg (control store, codes, condition struct).
module cmt_useq
    import cmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmt_cond_t        cond,
    output logic [ACT_W-1:0] act
);
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    cmt_uword_t       word;
    logic             taken;
    logic [UPC_W-1:0] disp_tgt;

    assign word = cmt_urom(upc_reg);
    assign act  = word.act;

    always_comb
    begin
        unique case (word.cond)
            C_ALWAYS:    taken = 1'b1;
            C_OUT_RANGE: taken = cond.out_range;
            C_BLK_MORE:  taken = cond.blk_more;
            C_PAST_LIM:  taken = cond.past_lim;
            C_SCAN_MISS: taken = cond.scan_miss;
            C_CLR_MORE:  taken = cond.clr_more;
            C_BOOT:      taken = cond.boot;
            C_OUT_BUSY:  taken = cond.out_busy;
            default:     taken = 1'b1;
        endcase
    end

    always_comb
    begin
        unique case (cond.op)
            OP_INSERT: disp_tgt = U_INS_RD;
            OP_REMOVE: disp_tgt = U_REM_RD;
            OP_QUERY:  disp_tgt = U_Q_BLK;
            OP_CLEAR:  disp_tgt = U_CLR_INIT;
            default:   disp_tgt = U_FETCH;
        endcase
    end

    always_comb
    begin
        if (word.disp)
        begin
            upc_next = cond.fire ? disp_tgt : upc_reg;
        end
        else
        begin
            upc_next = taken ? word.tgt_t : word.tgt_f;
        end
    end

    // Out of reset the program runs the store clearing pass first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLR_INIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end
endmodule

### hw/rtl/cmt_datapath.sv
`timescale 1ns / 1ps
// Datapath: count RAM, per-block distinct counters, scan pointers, result regs.
// Depends on cmt_pkg, cmt_req_if, cmt_rsp_if and cmt_ram.
module cmt_datapath
    import cmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LIM_W-1:0] cfg_wdata,
    cmt_req_if.sink          req,
    cmt_rsp_if.source        rsp,
    input  logic [ACT_W-1:0] act,
    output cmt_cond_t        cond
);
    logic [LIM_W-1:0]    limit_reg;
    logic [LIM_W-1:0]    limit_next;
    logic [LIM_W-1:0]    lim;

    logic [VALUE_W-1:0]  val_reg;
    logic [VALUE_W-1:0]  val_next;
    logic [LIM_W-1:0]    mex_reg;
    logic [LIM_W-1:0]    mex_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [BLK_W-1:0]    blk_reg;
    logic [BLK_W-1:0]    blk_next;
    logic [ADDR_W-1:0]   scan_reg;
    logic [ADDR_W-1:0]   scan_next;
    logic [ADDR_W-1:0]   chk_reg;
    logic [ADDR_W-1:0]   chk_next;
    logic                chk_valid_reg;
    logic                chk_valid_next;
    logic                boot_reg;
    logic                boot_next;
    logic [BCNT_W-1:0]   bcnt_reg [NUM_BLOCKS];
    logic [BCNT_W-1:0]   bcnt_next [NUM_BLOCKS];

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LIM_W-1:0]    out_mex_reg;
    logic [LIM_W-1:0]    out_mex_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [COUNT_W-1:0]  ram_rdata;

    logic                req_fire;
    logic                out_busy;
    logic                out_load;
    logic [BIDX_W-1:0]   vblk;
    logic [START_W-1:0]  start;
    logic                past_lim;
    logic                blk_stop;
    logic                scan_hit;
    logic [LIM_W-1:0]    hit_mex;

    cmt_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (VALUE_RANGE)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lim = (32'(limit_reg) < VALUE_RANGE) ? limit_reg : LIM_W'(VALUE_RANGE);

    assign req.ready = (act == A_FETCH);
    assign req_fire  = req.valid & req.ready;
    assign out_busy  = out_valid_reg & ~rsp.ready;

    assign vblk     = BIDX_W'(val_reg >> BLOCK_LOG2);
    assign start    = {blk_reg, BLOCK_LOG2'(0)};
    assign past_lim = 32'(start) >= 32'(lim);
    // Block counter index wraps once blk passes the last block; past_lim covers that case.
    assign blk_stop = past_lim || (bcnt_reg[blk_reg[BIDX_W-1:0]] != BCNT_W'(BLOCK_SIZE));
    assign scan_hit = chk_valid_reg && (ram_rdata == '0);
    assign hit_mex  = (32'(chk_reg) < 32'(lim)) ? LIM_W'(chk_reg) : lim;

    assign cond.fire      = req_fire;
    assign cond.op        = req.op;
    assign cond.out_range = !(32'(val_reg) < 32'(lim));
    assign cond.blk_more  = !blk_stop;
    assign cond.past_lim  = past_lim;
    assign cond.scan_miss = !scan_hit;
    assign cond.clr_more  = scan_reg != ADDR_W'(VALUE_RANGE - 1);
    assign cond.boot      = boot_reg;
    assign cond.out_busy  = out_busy;

    always_comb
    begin
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        val_next       = val_reg;
        mex_next       = mex_reg;
        status_next    = status_reg;
        blk_next       = blk_reg;
        scan_next      = scan_reg;
        chk_next       = chk_reg;
        chk_valid_next = chk_valid_reg;
        boot_next      = boot_reg;
        bcnt_next      = bcnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = val_reg;
        ram_wdata      = '0;
        ram_raddr      = scan_reg;
        out_load       = 1'b0;

        unique case (act)
            A_FETCH:
            begin
                if (req_fire)
                begin
                    val_next    = req.value;
                    mex_next    = '0;
                    status_next = ST_DONE;
                    blk_next    = '0;
                end
            end
            A_READ_VAL:
            begin
                ram_raddr = val_reg;
            end
            A_INC:
            begin
                if (ram_rdata == COUNT_MAX)
                begin
                    status_next = ST_SATURATED;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata + COUNT_W'(1);
                    if (ram_rdata == '0)
                    begin
                        bcnt_next[vblk] = bcnt_reg[vblk] + BCNT_W'(1);
                    end
                end
            end
            A_DEC:
            begin
                if (ram_rdata == '0)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata - COUNT_W'(1);
                    if (ram_rdata == COUNT_W'(1))
                    begin
                        bcnt_next[vblk] = bcnt_reg[vblk] - BCNT_W'(1);
                    end
                end
            end
            A_BLK_STEP:
            begin
                if (!blk_stop)
                begin
                    blk_next = blk_reg + BLK_W'(1);
                end
            end
            A_SCAN_INIT:
            begin
                scan_next      = start[ADDR_W-1:0];
                chk_valid_next = 1'b0;
            end
            A_SCAN:
            begin
                // read one entry a cycle; the data checked is from the previous address
                ram_raddr = scan_reg;
                // on a hit chk holds the address of the zero entry
                if (!scan_hit)
                begin
                    scan_next      = scan_reg + ADDR_W'(1);
                    chk_next       = scan_reg;
                    chk_valid_next = 1'b1;
                end
            end
            A_MEX_HIT:
            begin
                mex_next = hit_mex;
            end
            A_MEX_LIM:
            begin
                mex_next = lim;
            end
            A_CLR_INIT:
            begin
                scan_next = '0;
                for (int i = 0; i < NUM_BLOCKS; i++)
                begin
                    bcnt_next[i] = '0;
                end
            end
            A_CLR_STEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = '0;
                scan_next = scan_reg + ADDR_W'(1);
            end
            A_BOOT_DONE:
            begin
                boot_next = 1'b0;
            end
            A_EMIT:
            begin
                out_load = !out_busy;
            end
            default:
            begin
            end
        endcase

        out_valid_next  = out_load | out_busy;
        out_mex_next    = out_load ? mex_reg : out_mex_reg;
        out_status_next = out_load ? status_reg : out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            blk_reg       <= '0;
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                bcnt_reg[i] <= '0;
            end
        end
        else
        begin
            limit_reg     <= limit_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
            chk_valid_reg <= chk_valid_next;
            blk_reg       <= blk_next;
            bcnt_reg      <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg        <= val_next;
        mex_reg        <= mex_next;
        status_reg     <= status_next;
        scan_reg       <= scan_next;
        chk_reg        <= chk_next;
        out_mex_reg    <= out_mex_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.mex_value = out_mex_reg;
    assign rsp.status    = out_status_reg;
endmodule

### hw/rtl/counted_set_mex_tracker_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                      Handshake
// req      in   op[1:0], value[9:0]          valid/ready
// rsp      out  mex_value[10:0], status[1:0] valid/ready
// cfg      in   cfg_wdata[10:0] (limit)      cfg_we, no back-pressure
//
// Insert/remove: the count is read, then updated, then the result register is loaded (the
// update is skipped when the value is at or above the limit). Query: full blocks are
// skipped, then entries of the first partial block are scanned through the count RAM read
// port (one entry a cycle). Clear: every entry is zeroed in turn, then a result is emitted.
// After reset the same clearing pass runs with req.ready low.
// One item at a time; a new item is taken while the previous result waits in rsp.
// Depends on cmt_pkg, cmt_req_if, cmt_rsp_if, cmt_useq and cmt_datapath.
module counted_set_mex_tracker_core
    import cmt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LIM_W-1:0] cfg_wdata,
    cmt_req_if.sink          req,
    cmt_rsp_if.source        rsp
);
    logic [ACT_W-1:0] act;
    cmt_cond_t        cond;

    cmt_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .act   (act)
    );

    cmt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .act       (act),
        .cond      (cond)
    );
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for counted_set_mex_tracker_core: a scripted opening, random
// insert/remove/query/clear traffic under three idle mixes and a fill-to-limit sweep.
// Depends on cmt_pkg, cmt_req_if, cmt_rsp_if and the core RTL.
module tb;
    import cmt_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 80;
    localparam int N_ROWS       = 31;

    typedef enum logic {ROW_OP, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        logic [LIM_W-1:0]    mex;
        logic [STATUS_W-1:0] status;
    } mex_result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [VALUE_W-1:0]  value;
        logic                chk;     // mex/status typed in, not predicted
        logic [LIM_W-1:0]    mex;
        logic [STATUS_W-1:0] status;
    } req_item_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [OP_W-1:0]     op;
        logic [VALUE_W-1:0]  value;
        logic [LIM_W-1:0]    setting;
        logic                chk;
        logic [LIM_W-1:0]    mex;
        logic [STATUS_W-1:0] status;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [LIM_W-1:0] cfg_wdata;

    cmt_req_if req_ch ();
    cmt_rsp_if rsp_ch ();

    counted_set_mex_tracker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mirror of the store
    logic [COUNT_W-1:0] value_tally [VALUE_RANGE];
    int unsigned        block_fill  [NUM_BLOCKS];
    logic [LIM_W-1:0]   lim_reg = LIMIT_RESET;

    mex_result_t mex_status_q [$];
    req_item_t   offered_item;
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 28;
    int          recv_idle_pct = 82;
    logic        hold_toggle = 1'b0;

    stim_row_t script [N_ROWS] = '{
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_REMOVE, 0,    0,    1'b1, 0, ST_ABSENT},
        '{ROW_OP,    OP_REMOVE, 1023, 0,    1'b1, 0, ST_ABSENT},
        '{ROW_OP,    OP_INSERT, 0,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 1023, 0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  512,  0,    1'b1, 1, ST_DONE},
        '{ROW_OP,    OP_INSERT, 682,  0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 341,  0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 1,    0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 0,    0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_REMOVE, 0,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 2, ST_DONE},
        '{ROW_OP,    OP_REMOVE, 682,  0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_CLEAR,  1023, 0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 0, ST_DONE},
        '{ROW_LIMIT, OP_INSERT, 0,    2,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 0,    0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 1,    0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 2,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_REMOVE, 5,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 2, ST_DONE},
        '{ROW_LIMIT, OP_INSERT, 0,    0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_INSERT, 0,    0,    1'b1, 0, ST_DONE},
        '{ROW_OP,    OP_REMOVE, 1,    0,    1'b1, 0, ST_DONE},
        '{ROW_LIMIT, OP_INSERT, 0,    2047, 1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  1023, 0,    1'b0, 0, ST_DONE},
        '{ROW_LIMIT, OP_INSERT, 0,    1,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 1, ST_DONE},
        '{ROW_OP,    OP_REMOVE, 0,    0,    1'b0, 0, ST_DONE},
        '{ROW_OP,    OP_QUERY,  0,    0,    1'b1, 0, ST_DONE}
    };

    function automatic int unsigned active_limit();
        return (lim_reg < VALUE_RANGE) ? lim_reg : VALUE_RANGE;
    endfunction

    // Skip full blocks, then scan the first partial one; never answer above the limit.
    function automatic int unsigned lowest_absent();
        int unsigned lim;
        int unsigned first;
        lim = active_limit();
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            first = b * BLOCK_SIZE;
            if (first >= lim)
                return lim;
            if (block_fill[b] != BLOCK_SIZE)
                for (int j = first; j < first + BLOCK_SIZE && j < VALUE_RANGE; j++)
                    if (value_tally[j] == '0)
                        return (j < lim) ? j : lim;
        end
        return lim;
    endfunction

    function automatic mex_result_t count_and_answer(input logic [OP_W-1:0]    code,
                                                     input logic [VALUE_W-1:0] val);
        mex_result_t r;
        int unsigned blk;
        r.mex    = '0;
        r.status = ST_DONE;
        blk      = val / BLOCK_SIZE;
        case (code)
            OP_INSERT:
                if (val < active_limit())
                begin
                    if (value_tally[val] == COUNT_MAX)
                        r.status = ST_SATURATED;
                    else
                    begin
                        if (value_tally[val] == '0)
                            block_fill[blk]++;
                        value_tally[val]++;
                    end
                end
            OP_REMOVE:
                if (val < active_limit())
                begin
                    if (value_tally[val] == '0)
                        r.status = ST_ABSENT;
                    else
                    begin
                        if (value_tally[val] == 1)
                            block_fill[blk]--;
                        value_tally[val]--;
                    end
                end
            OP_QUERY:
                r.mex = LIM_W'(lowest_absent());
            default:
            begin
                foreach (value_tally[i])
                    value_tally[i] = '0;
                foreach (block_fill[i])
                    block_fill[i] = 0;
            end
        endcase
        return r;
    endfunction

    // Results are retired before new items are booked: a result never belongs
    // to the item accepted on the same edge.
    always @(posedge clk)
    begin : scoreboard
        mex_result_t want;
        mex_result_t pred;
        if (rst_n)
        begin
            if (cfg_we)
                lim_reg = cfg_wdata;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (mex_status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual mex %0d status %0d",
                             $time, rsp_ch.mex_value, rsp_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = mex_status_q.pop_front();
                    if (rsp_ch.mex_value !== want.mex)
                    begin
                        $display("%0t: mex_value expected %0d actual %0d",
                                 $time, want.mex, rsp_ch.mex_value);
                        mismatches++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                        mismatches++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                pred = count_and_answer(offered_item.op, offered_item.value);
                if (offered_item.chk)
                begin
                    want.mex    = offered_item.mex;
                    want.status = offered_item.status;
                end
                else
                    want = pred;
                mex_status_q.insert(mex_status_q.size(), want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("counted_set_mex_tracker_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random back-pressure, plus a long hold-off on each hold_toggle flip.
    initial
    begin
        int   stall_left;
        logic seen;
        stall_left   = 0;
        seen         = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != seen)
            begin
                seen       = hold_toggle;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Called at a clock edge; returns on the edge that accepts the item, valid left high.
    task automatic send_item(input req_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            req_ch.op    <= OP_W'($urandom);
            req_ch.value <= VALUE_W'($urandom);
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= it.op;
        req_ch.value <= it.value;
        offered_item <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Every item sent counts toward the quota.
    task automatic issue(input logic [OP_W-1:0] code, input logic [VALUE_W-1:0] val,
                         inout int n);
        req_item_t it;
        it.op     = code;
        it.value  = val;
        it.chk    = 1'b0;
        it.mex    = '0;
        it.status = ST_DONE;
        n++;
        send_item(it);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (mex_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] lim);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38)
            return OP_INSERT;
        if (r < 66)
            return OP_REMOVE;
        if (r < 98)
            return OP_QUERY;
        return OP_CLEAR;
    endfunction

    // Mostly the low window where blocks fill, some at the limit edge, some anywhere.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        int edge_lo;
        r = $urandom_range(0, 99);
        if (r < 65)
            return VALUE_W'($urandom_range(0, 95));
        if (r < 80)
        begin
            edge_lo = (active_limit() >= 2) ? active_limit() - 2 : 0;
            edge_lo = edge_lo + $urandom_range(0, 3);
            return VALUE_W'((edge_lo > VALUE_RANGE - 1) ? VALUE_RANGE - 1 : edge_lo);
        end
        return VALUE_W'($urandom);
    endfunction

    task automatic run_random(input int quota);
        int done_n;
        int base;
        int len;
        int pick;
        done_n = 0;
        while (done_n < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                // fill run: sometimes a clear, ascending inserts with a few holes, then probes and removes
                if ($urandom_range(0, 3) == 0)
                    issue(OP_CLEAR, VALUE_W'($urandom), done_n);
                base = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) : 0;
                len  = $urandom_range(8, 72);
                for (int k = 0; k < len; k++)
                    if ($urandom_range(0, 19) != 0)
                        issue(OP_INSERT, VALUE_W'(base + k), done_n);
                issue(OP_QUERY, VALUE_W'($urandom), done_n);
                repeat ($urandom_range(0, 3))
                    issue(OP_REMOVE, VALUE_W'($urandom_range(0, base + len)), done_n);
                issue(OP_QUERY, VALUE_W'($urandom), done_n);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(4, 12))
                    issue(pick_op(), pick_value(), done_n);
            end
            else
            begin
                repeat (4)
                    issue(OP_W'($urandom_range(0, 2)), VALUE_W'($urandom), done_n);
            end
        end
    endtask

    initial
    begin
        req_item_t row_item;
        int        extra_n;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_INSERT;
        req_ch.value = '0;
        extra_n      = 0;
        foreach (value_tally[i])
            value_tally[i] = '0;
        foreach (block_fill[i])
            block_fill[i] = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].kind == ROW_LIMIT)
                write_limit(script[r].setting);
            else
            begin
                row_item.op     = script[r].op;
                row_item.value  = script[r].value;
                row_item.chk    = script[r].chk;
                row_item.mex    = script[r].mex;
                row_item.status = script[r].status;
                send_item(row_item);
            end
        end

        // slow receiver; long hold-off fills the block while items keep coming
        write_limit(LIMIT_RESET);
        hold_toggle <= ~hold_toggle;
        run_random(80);
        write_limit(70);
        run_random(80);

        write_limit(37);
        send_idle_pct = 82;
        recv_idle_pct = 28;
        run_random(80);
        write_limit(2047);
        run_random(80);

        write_limit(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(80);
        write_limit(100);
        hold_toggle <= ~hold_toggle;
        run_random(80);

        // every value below the limit present: answer equals the limit; a raised limit and removals move it
        write_limit(64);
        issue(OP_CLEAR, '0, extra_n);
        for (int v = 0; v < 64; v++)
            issue(OP_INSERT, VALUE_W'(v), extra_n);
        issue(OP_QUERY, '0, extra_n);
        write_limit(70);
        issue(OP_QUERY, '0, extra_n);
        for (int v = 64; v < 70; v++)
            issue(OP_INSERT, VALUE_W'(v), extra_n);
        issue(OP_QUERY, '0, extra_n);
        issue(OP_REMOVE, VALUE_W'(69), extra_n);
        issue(OP_QUERY, '0, extra_n);
        issue(OP_REMOVE, VALUE_W'(40), extra_n);
        issue(OP_QUERY, '0, extra_n);

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && mex_status_q.size() == 0)
            $display("counted_set_mex_tracker_core verification clean");
        else
            $display("counted_set_mex_tracker_core verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/cmt_pkg.sv
hw/rtl/cmt_req_if.sv
hw/rtl/cmt_rsp_if.sv
hw/rtl/cmt_ram.sv
hw/rtl/cmt_useq.sv
hw/rtl/cmt_datapath.sv
hw/rtl/counted_set_mex_tracker_core.sv
tb/sv/tb.sv
